// ===== hdl/slc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slc_pkg
// Shared constants, types and the slice hash of the sliced LRU set counter.
// ----------------------------------------------------------------------------
package slc_pkg;

    localparam int ADDR_W        = 53;
    localparam int FULL_ADDR_W   = 54;
    localparam int SLICE_W       = 3;
    localparam int LINE_OFS_W    = 6;
    localparam int SET_IDX_W_DEF = 11;
    localparam int WAYS_DEF      = 16;
    localparam int CFG_W         = 5;
    localparam int FILL_W        = 5;
    localparam int WAY_W         = 4;
    localparam int CNT_W         = 32;
    localparam int SET_OUT_W     = 11;
    localparam logic [CFG_W-1:0] ACTIVE_WAYS_RST = 5'd11;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_LOOK  = 3'b100
    } t_state;

    // Outcome of the way search for one item.
    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] way;
        logic             fill_inc;
    } t_way_res;

    // Three XOR parity functions over address bits 6 to 37.
    function automatic logic [SLICE_W-1:0] slice_hash(input logic [FULL_ADDR_W-1:0] a);
        logic p_hi;
        logic p_mid;
        logic p_lo;
        p_hi  = a[37] ^ a[36] ^ a[35] ^ a[34] ^ a[31] ^ a[30] ^ a[27] ^ a[26]
              ^ a[23] ^ a[22] ^ a[19] ^ a[16] ^ a[13] ^ a[12] ^ a[8];
        p_mid = a[37] ^ a[35] ^ a[34] ^ a[33] ^ a[31] ^ a[29] ^ a[28] ^ a[26]
              ^ a[24] ^ a[23] ^ a[22] ^ a[21] ^ a[20] ^ a[19] ^ a[17] ^ a[15]
              ^ a[13] ^ a[11] ^ a[7];
        p_lo  = a[36] ^ a[35] ^ a[33] ^ a[32] ^ a[30] ^ a[28] ^ a[27] ^ a[26]
              ^ a[25] ^ a[24] ^ a[22] ^ a[20] ^ a[18] ^ a[17] ^ a[16] ^ a[14]
              ^ a[12] ^ a[10] ^ a[6];
        return {p_hi, p_mid, p_lo};
    endfunction

endpackage
`default_nettype wire

// ===== hdl/slc_way_ctl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slc_way_ctl
// Tag compare, fill or victim choice and LRU reorder for one set row.
// ----------------------------------------------------------------------------
module slc_way_ctl #(
    parameter int WAYS  = slc_pkg::WAYS_DEF,
    parameter int TAG_W = 37
) (
    input  wire logic [WAYS*TAG_W-1:0]          i_tags,
    input  wire logic [TAG_W-1:0]               i_tag,
    input  wire logic [slc_pkg::FILL_W-1:0]     i_fill,
    input  wire logic [slc_pkg::FILL_W-1:0]     i_eff,
    input  wire logic [WAYS*slc_pkg::WAY_W-1:0] i_lru,
    output slc_pkg::t_way_res                   o_res,
    output logic [WAYS*slc_pkg::WAY_W-1:0]      o_lru
);

    localparam int WW = slc_pkg::WAY_W;

    logic [slc_pkg::FILL_W-1:0] valid;
    logic                       hit;
    logic [WW-1:0]              hit_way;
    logic [WW-1:0]              victim;
    logic [WW-1:0]              way;
    logic [WW-1:0]              pos;

    always_comb begin
        valid   = (i_fill < i_eff) ? i_fill : i_eff;
        hit     = 1'b0;
        hit_way = '0;
        // Descending scan so the lowest matching way wins.
        for (int w = WAYS - 1; w >= 0; w--) begin
            if ((slc_pkg::FILL_W'(w) < valid) && (i_tags[w*TAG_W +: TAG_W] == i_tag)) begin
                hit     = 1'b1;
                hit_way = WW'(w);
            end
        end
        // Least recent way inside the active range: highest rank wins.
        victim = '0;
        for (int r = 0; r < WAYS; r++) begin
            if ({1'b0, i_lru[r*WW +: WW]} < i_eff) begin
                victim = i_lru[r*WW +: WW];
            end
        end
        o_res.hit      = hit;
        o_res.fill_inc = !hit && (i_fill < i_eff);
        if (hit) begin
            way = hit_way;
        end else if (i_fill < i_eff) begin
            way = i_fill[WW-1:0];
        end else begin
            way = victim;
        end
        o_res.way = way;
        pos = WW'(WAYS - 1);
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (i_lru[i*WW +: WW] == way) begin
                pos = WW'(i);
            end
        end
        o_lru[0 +: WW] = way;
        for (int i = 1; i < WAYS; i++) begin
            if (WW'(i) <= pos) begin
                o_lru[i*WW +: WW] = i_lru[(i-1)*WW +: WW];
            end else begin
                o_lru[i*WW +: WW] = i_lru[i*WW +: WW];
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/sliced_lru_cache_set_counter_top.sv =====
`default_nettype none
// An accepted item's set record and tag row are registered; its result enters the output
// register when its lookup cycle ends, and no new item is accepted before its write-back.
// A full output register that is stalled holds the next item in its lookup cycle.
// Reset is synchronous, active low; afterward a clearing pass writes all
// 8 * 2**SET_IDX_W set records (16384 by default), while no item is accepted.
// ----------------------------------------------------------------------------
// sliced_lru_cache_set_counter_top
// Sliced set-associative cache model with true LRU and per-set counters.
// ----------------------------------------------------------------------------
module sliced_lru_cache_set_counter_top #(
    parameter int SET_IDX_W = slc_pkg::SET_IDX_W_DEF,
    parameter int WAYS      = slc_pkg::WAYS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [slc_pkg::CFG_W-1:0]     i_cfg_wr_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [slc_pkg::ADDR_W-1:0]    i_address,
    input  wire logic                          i_source_bit,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_hit,
    output logic [slc_pkg::SLICE_W-1:0]        o_slice_index,
    output logic [slc_pkg::SET_OUT_W-1:0]      o_set_index,
    output logic [slc_pkg::WAY_W-1:0]          o_way_index,
    output logic [slc_pkg::CNT_W-1:0]          o_set_access_count,
    output logic [slc_pkg::CNT_W-1:0]          o_set_miss_count
);

    // Derived geometry. The set memory is indexed by {slice, set}.
    localparam int TAG_W   = slc_pkg::FULL_ADDR_W - SET_IDX_W - slc_pkg::LINE_OFS_W;
    localparam int IDX_W   = slc_pkg::SLICE_W + SET_IDX_W;
    localparam int DEPTH   = 1 << IDX_W;
    localparam int LRU_W   = WAYS * slc_pkg::WAY_W;
    localparam int CW      = slc_pkg::CNT_W;
    localparam int FW      = slc_pkg::FILL_W;
    localparam int REC_W   = FW + LRU_W + 2 * CW;
    localparam int ROW_W   = WAYS * TAG_W;

    // Record layout, from high to low: fill level, LRU order, access count, miss count.
    localparam int MISS_LO = 0;
    localparam int ACC_LO  = CW;
    localparam int LRU_LO  = 2 * CW;
    localparam int FILL_LO = 2 * CW + LRU_W;

    function automatic logic [LRU_W-1:0] lru_init();
        logic [LRU_W-1:0] v;
        for (int i = 0; i < WAYS; i++) begin
            v[i*slc_pkg::WAY_W +: slc_pkg::WAY_W] = slc_pkg::WAY_W'(i);
        end
        return v;
    endfunction

    // The two memories: per-set state record and per-set tag row.
    // The tag row has no reset; only entries below the fill level are compared.
    logic [REC_W-1:0] mem_set [DEPTH];
    logic [ROW_W-1:0] mem_tag [DEPTH];

    slc_pkg::t_state           r_state, n_state;
    logic [IDX_W-1:0]          r_clr_addr;
    logic [slc_pkg::CFG_W-1:0] r_active_ways;

    // Registered read data and the latched item.
    logic [REC_W-1:0]            r_rec_rd;
    logic [ROW_W-1:0]            r_row_rd;
    logic [TAG_W-1:0]            r_tag;
    logic [slc_pkg::SLICE_W-1:0] r_slice;
    logic [SET_IDX_W-1:0]        r_set;

    logic                        r_out_valid;
    logic                        r_hit;
    logic [slc_pkg::SLICE_W-1:0] r_out_slice;
    logic [SET_IDX_W-1:0]        r_out_set;
    logic [slc_pkg::WAY_W-1:0]   r_out_way;
    logic [CW-1:0]               r_out_acc;
    logic [CW-1:0]               r_out_miss;

    logic [slc_pkg::FULL_ADDR_W-1:0] in_addr;
    logic [slc_pkg::SLICE_W-1:0]     in_slice;
    logic [SET_IDX_W-1:0]            in_set;
    logic [IDX_W-1:0]                in_idx;
    logic                            in_accept;
    logic                            finish;

    logic [FW-1:0]       eff;
    logic [FW-1:0]       old_fill;
    logic [CW-1:0]       old_acc;
    logic [CW-1:0]       old_miss;
    logic [FW-1:0]       new_fill;
    logic [CW-1:0]       new_acc;
    logic [CW-1:0]       new_miss;
    logic [LRU_W-1:0]    new_lru;
    logic [REC_W-1:0]    new_rec;
    logic [ROW_W-1:0]    new_row;
    slc_pkg::t_way_res   res;

    logic [SET_IDX_W+slc_pkg::SET_OUT_W-1:0] set_ext;

    // The source bit sits above the address so the two requesters never share a tag.
    assign in_addr   = {i_source_bit, i_address};
    assign in_slice  = slc_pkg::slice_hash(in_addr);
    assign in_set    = in_addr[slc_pkg::LINE_OFS_W +: SET_IDX_W];
    assign in_idx    = {in_slice, in_set};
    assign o_in_stall = (r_state != slc_pkg::S_IDLE);
    assign in_accept = i_in_valid && !o_in_stall;

    // The lookup cycle ends only when the output register is free or being emptied.
    assign finish = (r_state == slc_pkg::S_LOOK) && !(r_out_valid && i_out_stall);

    // Way count clamped to 1..WAYS.
    always_comb begin
        if (r_active_ways == '0) begin
            eff = FW'(1);
        end else if (r_active_ways > FW'(WAYS)) begin
            eff = FW'(WAYS);
        end else begin
            eff = r_active_ways;
        end
    end

    assign old_fill = r_rec_rd[FILL_LO +: FW];
    assign old_acc  = r_rec_rd[ACC_LO +: CW];
    assign old_miss = r_rec_rd[MISS_LO +: CW];

    slc_way_ctl #(
        .WAYS  (WAYS),
        .TAG_W (TAG_W)
    ) u_way_ctl (
        .i_tags (r_row_rd),
        .i_tag  (r_tag),
        .i_fill (old_fill),
        .i_eff  (eff),
        .i_lru  (r_rec_rd[LRU_LO +: LRU_W]),
        .o_res  (res),
        .o_lru  (new_lru)
    );

    // Saturating counters and the fill step, then the record and tag row to write back.
    always_comb begin
        new_acc  = (old_acc == '1) ? old_acc : old_acc + CW'(1);
        new_miss = (res.hit || old_miss == '1) ? old_miss : old_miss + CW'(1);
        new_fill = res.fill_inc ? old_fill + FW'(1) : old_fill;
        new_rec  = {new_fill, new_lru, new_acc, new_miss};
        new_row  = r_row_rd;
        for (int w = 0; w < WAYS; w++) begin
            if (res.way == slc_pkg::WAY_W'(w)) begin
                new_row[w*TAG_W +: TAG_W] = r_tag;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            slc_pkg::S_CLEAR: begin
                if (r_clr_addr == '1) n_state = slc_pkg::S_IDLE;
            end
            slc_pkg::S_IDLE: begin
                if (in_accept) n_state = slc_pkg::S_LOOK;
            end
            slc_pkg::S_LOOK: begin
                if (finish) n_state = slc_pkg::S_IDLE;
            end
            default: n_state = slc_pkg::S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= slc_pkg::S_CLEAR;
            r_clr_addr    <= '0;
            r_active_ways <= slc_pkg::ACTIVE_WAYS_RST;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == slc_pkg::S_CLEAR) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
            end
            if (i_cfg_wr_en) begin
                r_active_ways <= i_cfg_wr_data;
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Set record memory: one read port at accept, one write port for clear and write-back.
    always_ff @(posedge i_clk) begin
        if (r_state == slc_pkg::S_CLEAR) begin
            mem_set[r_clr_addr] <= {FW'(0), lru_init(), CW'(0), CW'(0)};
        end else if (finish) begin
            mem_set[{r_slice, r_set}] <= new_rec;
        end
        if (in_accept) begin
            r_rec_rd <= mem_set[in_idx];
        end
    end

    // Tag row memory: rewritten only when a miss places a new tag.
    always_ff @(posedge i_clk) begin
        if (finish && !res.hit) begin
            mem_tag[{r_slice, r_set}] <= new_row;
        end
        if (in_accept) begin
            r_row_rd <= mem_tag[in_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_tag   <= in_addr[slc_pkg::FULL_ADDR_W-1 -: TAG_W];
            r_slice <= in_slice;
            r_set   <= in_set;
        end
        if (finish) begin
            r_hit       <= res.hit;
            r_out_slice <= r_slice;
            r_out_set   <= r_set;
            r_out_way   <= res.way;
            r_out_acc   <= new_acc;
            r_out_miss  <= new_miss;
        end
    end

    // The set index shows only its low eleven bits when the set field is wider.
    assign set_ext = {{slc_pkg::SET_OUT_W{1'b0}}, r_out_set};

    assign o_out_valid        = r_out_valid;
    assign o_hit              = r_hit;
    assign o_slice_index      = r_out_slice;
    assign o_set_index        = set_ext[slc_pkg::SET_OUT_W-1:0];
    assign o_way_index        = r_out_way;
    assign o_set_access_count = r_out_acc;
    assign o_set_miss_count   = r_out_miss;

endmodule
`default_nettype wire

// ===== dv/slc_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slc_checker
// Watches both channels of the sliced LRU set counter, keeps its own copy of
// the cache state and compares every result with the predicted one.
// ----------------------------------------------------------------------------
module slc_checker (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [slc_pkg::CFG_W-1:0]    i_cfg_wr_data,
    input  wire logic                         i_in_valid,
    input  wire logic                         i_in_stall,
    input  wire logic [slc_pkg::ADDR_W-1:0]   i_address,
    input  wire logic                         i_source_bit,
    input  wire logic                         i_out_valid,
    input  wire logic                         i_out_stall,
    input  wire logic                         i_hit,
    input  wire logic [slc_pkg::SLICE_W-1:0]  i_slice_index,
    input  wire logic [slc_pkg::SET_OUT_W-1:0] i_set_index,
    input  wire logic [slc_pkg::WAY_W-1:0]    i_way_index,
    input  wire logic [slc_pkg::CNT_W-1:0]    i_set_access_count,
    input  wire logic [slc_pkg::CNT_W-1:0]    i_set_miss_count,
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_result_count,
    output int                                o_hit_count,
    output int                                o_evict_count
);

    typedef struct {
        bit             hit;
        bit [2:0]       slice_idx;
        bit [10:0]      set_idx;
        bit [3:0]       way;
        bit [31:0]      acc_cnt;
        bit [31:0]      miss_cnt;
    } t_lookup;

    localparam int HI_BITS[15]  = '{37,36,35,34,31,30,27,26,23,22,19,16,13,12,8};
    localparam int MID_BITS[19] = '{37,35,34,33,31,29,28,26,24,23,22,21,20,19,17,15,
                                    13,11,7};
    localparam int LO_BITS[19]  = '{36,35,33,32,30,28,27,26,25,24,22,20,18,17,16,14,
                                    12,10,6};
    localparam bit [63:0] LRU_INIT = 64'hFEDC_BA98_7654_3210;
    localparam bit [31:0] CNT_SAT  = 32'hFFFF_FFFF;

    // Sparse copy of the set records; untouched sets read as their reset value.
    bit [36:0]  tag_mem[int];
    bit [4:0]   fill_mem[int];
    bit [63:0]  lru_mem[int];
    bit [31:0]  acc_mem[int];
    bit [31:0]  miss_mem[int];
    bit [4:0]   ways_cfg;
    t_lookup    lookups_due[$];

    function automatic bit [2:0] xor_slice(bit [53:0] a);
        bit [2:0] s;
        s = '0;
        foreach (HI_BITS[i])  s[2] ^= a[HI_BITS[i]];
        foreach (MID_BITS[i]) s[1] ^= a[MID_BITS[i]];
        foreach (LO_BITS[i])  s[0] ^= a[LO_BITS[i]];
        return s;
    endfunction

    function automatic t_lookup access_cache(bit [52:0] addr, bit src);
        t_lookup   r;
        bit [53:0] a;
        bit [36:0] tag;
        bit [63:0] order;
        bit [4:0]  fill;
        bit [3:0]  ranks[16];
        int        idx, eff, valid, p;
        a         = {src, addr};
        tag       = a[53:17];
        r.slice_idx = xor_slice(a);
        r.set_idx = a[16:6];
        idx       = r.slice_idx * 2048 + r.set_idx;
        eff       = (ways_cfg < 1) ? 1 : (ways_cfg > 16) ? 16 : ways_cfg;
        fill      = fill_mem.exists(idx) ? fill_mem[idx] : 5'd0;
        order     = lru_mem.exists(idx) ? lru_mem[idx] : LRU_INIT;
        r.acc_cnt  = acc_mem.exists(idx) ? acc_mem[idx] : 32'd0;
        r.miss_cnt = miss_mem.exists(idx) ? miss_mem[idx] : 32'd0;
        valid     = (fill < eff) ? fill : eff;
        if (r.acc_cnt != CNT_SAT) r.acc_cnt++;
        r.hit = 1'b0;
        r.way = '0;
        for (int w = 0; w < valid; w++) begin
            if (tag_mem[idx * 16 + w] == tag) begin
                r.hit = 1'b1;
                r.way = 4'(w);
                break;
            end
        end
        for (int i = 0; i < 16; i++) ranks[i] = order[4*i +: 4];
        if (!r.hit) begin
            if (r.miss_cnt != CNT_SAT) r.miss_cnt++;
            if (fill < eff) begin
                r.way = fill[3:0];
                fill_mem[idx] = fill + 5'd1;
            end else begin
                // Full set: the least recent way still inside the active count goes.
                for (int k = 15; k >= 0; k--) begin
                    if (ranks[k] < eff) begin
                        r.way = ranks[k];
                        break;
                    end
                end
                o_evict_count++;
            end
            tag_mem[idx * 16 + r.way] = tag;
        end
        p = 15;
        for (int i = 0; i < 16; i++) begin
            if (ranks[i] == r.way) begin
                p = i;
                break;
            end
        end
        for (int i = p; i > 0; i--) ranks[i] = ranks[i-1];
        ranks[0] = r.way;
        for (int i = 0; i < 16; i++) order[4*i +: 4] = ranks[i];
        lru_mem[idx]  = order;
        acc_mem[idx]  = r.acc_cnt;
        miss_mem[idx] = r.miss_cnt;
        return r;
    endfunction

    function automatic void report(string what, longint unsigned want, longint unsigned got);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("mismatch at %0t: %s expected %0d, got %0d", $realtime, what, want, got);
    endfunction

    initial begin
        o_fail_count   = 0;
        o_result_count = 0;
        o_hit_count    = 0;
        o_evict_count  = 0;
        o_pending      = 0;
        ways_cfg       = slc_pkg::ACTIVE_WAYS_RST;
    end

    always @(posedge i_clk) begin
        t_lookup want;
        if (!i_rst_n) begin
            tag_mem.delete();
            fill_mem.delete();
            lru_mem.delete();
            acc_mem.delete();
            miss_mem.delete();
            lookups_due.delete();
            ways_cfg = slc_pkg::ACTIVE_WAYS_RST;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                o_result_count++;
                if (lookups_due.size() == 0) begin
                    report("unexpected result, hit", 0, i_hit);
                end else begin
                    want = lookups_due.pop_front();
                    if (want.hit) o_hit_count++;
                    if (i_hit !== want.hit) report("hit", want.hit, i_hit);
                    if (i_slice_index !== want.slice_idx)
                        report("slice_index", want.slice_idx, i_slice_index);
                    if (i_set_index !== want.set_idx)
                        report("set_index", want.set_idx, i_set_index);
                    if (i_way_index !== want.way) report("way_index", want.way, i_way_index);
                    if (i_set_access_count !== want.acc_cnt)
                        report("set_access_count", want.acc_cnt, i_set_access_count);
                    if (i_set_miss_count !== want.miss_cnt)
                        report("set_miss_count", want.miss_cnt, i_set_miss_count);
                end
            end
            if (i_in_valid && !i_in_stall)
                lookups_due.push_back(access_cache(i_address, i_source_bit));
            if (i_cfg_wr_en) ways_cfg = i_cfg_wr_data;
        end
        o_pending = lookups_due.size();
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the sliced LRU set counter: directed corner items,
// then random phases under several way counts, with random idling on both
// channels and a checker module that predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;

    // The clearing pass after reset accepts nothing, and the longest receiver
    // hold is LONG_HOLD, so this limit on cycles without any accepted item
    // lies well above the worst case.
    localparam int IDLE_LIMIT = 100000;
    localparam int LONG_HOLD  = 90;
    localparam int PHASE_ITEMS = 150;
    localparam int AW         = slc_pkg::ADDR_W;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_wr_en = 1'b0;
    logic [slc_pkg::CFG_W-1:0]       i_cfg_wr_data = '0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_stall;
    logic [slc_pkg::ADDR_W-1:0]      i_address = '0;
    logic                            i_source_bit = 1'b0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    logic                            o_hit;
    logic [slc_pkg::SLICE_W-1:0]     o_slice_index;
    logic [slc_pkg::SET_OUT_W-1:0]   o_set_index;
    logic [slc_pkg::WAY_W-1:0]       o_way_index;
    logic [slc_pkg::CNT_W-1:0]       o_set_access_count;
    logic [slc_pkg::CNT_W-1:0]       o_set_miss_count;

    int fail_count, pending, result_count, hit_count, evict_count;
    int items_sent = 0;
    int quiet_cycles = 0;
    // While set, neither side idles, giving a stretch of back-to-back items.
    bit steady_run = 1'b0;
    // The sender raises this once to ask the receiver for a long hold-off.
    bit hold_asked = 1'b0;

    // Small pools of low and high address parts. Keeping bits 6 to 37 from a
    // few bases pins the slice and set, while the high parts give many tags
    // to one set, so that sets fill, hit and evict.
    logic [37:0] set_bases[4];
    logic [14:0] tag_highs[24];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    sliced_lru_cache_set_counter_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_address(i_address), .i_source_bit(i_source_bit),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_hit(o_hit), .o_slice_index(o_slice_index), .o_set_index(o_set_index),
        .o_way_index(o_way_index), .o_set_access_count(o_set_access_count),
        .o_set_miss_count(o_set_miss_count)
    );

    slc_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall),
        .i_address(i_address), .i_source_bit(i_source_bit),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_hit(o_hit), .i_slice_index(o_slice_index), .i_set_index(o_set_index),
        .i_way_index(o_way_index), .i_set_access_count(o_set_access_count),
        .i_set_miss_count(o_set_miss_count),
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count),
        .o_hit_count(hit_count), .o_evict_count(evict_count)
    );

    // Offer one item and hold it until the block takes it. Outputs of the
    // block change only through nonblocking updates, so reading o_in_stall
    // right after the edge sees the value that decided acceptance.
    task automatic send_item(input logic [slc_pkg::ADDR_W-1:0] addr, input logic src);
        i_in_valid   <= 1'b1;
        i_address    <= addr;
        i_source_bit <= src;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        if (!steady_run && $urandom_range(99) < 38) begin
            i_in_valid <= 1'b0;
            i_address  <= AW'({$urandom, $urandom});
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic send_pooled(input int base_sel, input int tag_sel, input logic src);
        send_item({tag_highs[tag_sel], set_bases[base_sel]}, src);
    endtask

    // Drop the valid, wait for every expected result, let the pipeline drain,
    // then write the way count while the block is idle.
    task automatic set_way_count(input logic [slc_pkg::CFG_W-1:0] ways);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= ways;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // Mostly accesses from the pools, with a share of fully random addresses.
    task automatic random_phase(input int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 20)
                send_item(AW'({$urandom, $urandom}), 1'($urandom_range(1)));
            else
                send_pooled($urandom_range(3), $urandom_range(23), 1'($urandom_range(1)));
            if (items_sent == 450) hold_asked = 1'b1;
            steady_run = (items_sent >= 600 && items_sent < 700);
        end
    endtask

    // Receiver: random stalls, one long hold-off on request, and no stalls
    // during the steady stretch.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_asked) begin
                hold_asked = 1'b0;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !steady_run && ($urandom_range(99) < 38);
            end
        end
    end

    // Watchdog: counts cycles in which neither channel accepts an item.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("timeout: no item accepted for %0d cycles", IDLE_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        logic [slc_pkg::CFG_W-1:0] phase_ways[6];
        phase_ways = '{5'd16, 5'd4, 5'd1, 5'd0, 5'd31, 5'd11};
        foreach (set_bases[i]) set_bases[i] = 38'({$urandom, $urandom});
        foreach (tag_highs[i]) tag_highs[i] = 15'($urandom);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, under the reset way count of eleven. Address zero
        // from both sources shares a set but not a tag; all ones likewise.
        send_item('0, 1'b0);
        send_item('0, 1'b1);
        send_item('0, 1'b0);
        send_item('1, 1'b0);
        send_item('1, 1'b1);
        send_item('1, 1'b1);
        // Twelve distinct tags into one set: fills all eleven ways and then
        // evicts the least recent line; the first tag is gone afterward.
        for (int t = 0; t < 12; t++) send_pooled(0, t, 1'b0);
        send_pooled(0, 0, 1'b0);
        send_pooled(0, 11, 1'b0);
        // Sender pauses until every expected result has arrived.
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);

        // Random phases under several way counts. Going from sixteen down to
        // four and one exercises a lowered way count on filled sets, and the
        // later raise to the maximum can expose duplicate tags within a set.
        foreach (phase_ways[p]) begin
            set_way_count(phase_ways[p]);
            random_phase(PHASE_ITEMS);
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("covered %0d items, %0d results: %0d hits, %0d evictions",
                 items_sent, result_count, hit_count, evict_count);
        $display("way counts 11, 16, 4, 1, 0, 31 and 11; %0d mismatches", fail_count);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
